>>> rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the table linear interpolator
// Table size, fixed point constants, codes, sequencer states, divider result.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CW     = $clog2(DIV_STEPS);

    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam logic [6:0]  MAX_PTS_C = 7'(MAX_POINTS);

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST  = 2'd0;
    localparam logic [1:0] CFG_STEP   = 2'd1;
    localparam logic [1:0] CFG_POINTS = 2'd2;

    // range status codes
    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_BELOW  = 2'd1;
    localparam logic [1:0] ST_END    = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_CHECK,
        S_END,
        S_RD_B,
        S_MUL_A,
        S_MUL_B,
        S_ADD,
        S_DIV2
    } t_state;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
        logic [15:0] remainder;
    } t_div_res;

endpackage

`default_nettype wire

>>> rtl/tli_divider.sv
// ----------------------------------------------------------------------------
// tli_divider: serial restoring divider
// 32-bit dividend by 16-bit divisor, one quotient bit a cycle; the upper half
// of the dividend must be below the divisor so the quotient fits 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_dividend,
    input  wire logic [15:0]        i_divisor,
    output tli_pkg::t_div_res       o_res
);

    logic                        r_busy;
    logic                        r_done;
    logic [tli_pkg::DIV_CW-1:0]  r_count;
    logic [15:0]                 r_rem;
    logic [15:0]                 r_q;
    logic [15:0]                 r_div;

    logic [16:0] shifted;
    logic        ge;
    logic [16:0] diff;

    always_comb begin
        shifted = {r_rem, r_q[15]};
        ge      = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= tli_pkg::DIV_CW'(tli_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                r_count <= r_count - tli_pkg::DIV_CW'(1);
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[31:16];
            r_q   <= i_dividend[15:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            // low dividend bits shift out as quotient bits shift in
            r_rem <= ge ? diff[15:0] : shifted[15:0];
            r_q   <= {r_q[14:0], ge};
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_q;
    assign o_res.remainder = r_rem;

endmodule

`default_nettype wire

>>> rtl/tli_point_mem.sv
// ----------------------------------------------------------------------------
// tli_point_mem: curve point storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_point_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [tli_pkg::PT_AW-1:0] i_waddr,
    input  wire logic [15:0]               i_wdata,
    input  wire logic [tli_pkg::PT_AW-1:0] i_raddr,
    output logic [15:0]                    o_rdata
);

    logic [15:0] r_mem [tli_pkg::MAX_POINTS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise-linear transmittance table lookup
// Loads curve points and answers wavelength queries by linear interpolation.
// ----------------------------------------------------------------------------
// A load item writes one point in the cycle it is accepted and gives no result;
// busy stays low, so the next item may follow at once. A query for an empty
// table or a wavelength below the first point answers on o_result_valid in the
// cycle after acceptance with busy low. A query at or past the last point keeps
// busy high for one pass of the shared 16-step serial divider for the segment
// index, a check and a table read. Any other query keeps busy high for two
// divider passes (segment index, then the rounded weighted sum) plus table
// reads, two passes of one multiplier and an add. The result is strobed in the
// cycle busy falls. Each result is shown for exactly one cycle and the receiver
// cannot hold it off.
// Configuration writes are always taken (o_cfg_ready is high) and must be made
// while the block is idle.
`default_nettype none

module table_linear_interpolator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_opcode,
    input  wire logic [5:0]  i_point_index,
    input  wire logic [15:0] i_point_value,
    input  wire logic [15:0] i_wavelength,
    output logic             o_result_valid,
    output logic [15:0]      o_transmittance,
    output logic [1:0]       o_range_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    tli_pkg::t_state r_state, n_state;

    logic [15:0] r_first;
    logic [15:0] r_step;
    logic [6:0]  r_points;

    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_trans, n_out_trans;
    logic [1:0]  r_out_status, n_out_status;

    logic [15:0] r_quot;
    logic [15:0] r_rem;
    logic [15:0] r_a;
    logic [15:0] r_b;
    logic [31:0] r_prod;
    logic [31:0] r_acc;

    logic                       accept;
    logic                       mem_we;
    logic [15:0]                load_val;
    logic [tli_pkg::PT_AW-1:0]  mem_raddr;
    logic [15:0]                mem_rdata;
    logic                       div_start;
    logic [31:0]                div_dividend;
    tli_pkg::t_div_res          div_res;
    logic [15:0]                step_eff;
    logic [6:0]                 n_eff;
    logic [6:0]                 n_m1;
    logic                       at_end;
    logic [15:0]                mul_x;
    logic [15:0]                mul_y;
    logic [31:0]                mul_p;

    assign accept      = start && !busy;
    assign busy        = (r_state != tli_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign step_eff = (r_step == '0) ? 16'd1 : r_step;
    assign n_eff    = (r_points > tli_pkg::MAX_PTS_C) ? tli_pkg::MAX_PTS_C : r_points;
    assign n_m1     = n_eff - 7'd1;
    assign at_end   = r_quot >= {9'b0, n_m1};

    assign load_val = (i_point_value > tli_pkg::ONE_Q15) ? tli_pkg::ONE_Q15 : i_point_value;
    assign mem_we   = accept && (i_opcode == tli_pkg::OP_LOAD);

    // one multiplier: left weight first, right weight next
    assign mul_x = (r_state == tli_pkg::S_MUL_A) ? r_a : r_b;
    assign mul_y = (r_state == tli_pkg::S_MUL_A) ? (step_eff - r_rem) : r_rem;
    assign mul_p = 32'(mul_x) * 32'(mul_y);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_step   <= 16'd16;
            r_points <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tli_pkg::CFG_FIRST:  r_first  <= i_cfg_data;
                tli_pkg::CFG_STEP:   r_step   <= i_cfg_data;
                tli_pkg::CFG_POINTS: r_points <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    tli_point_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_point_index),
        .i_wdata (load_val),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tli_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (step_eff),
        .o_res      (div_res)
    );

    always_comb begin
        n_state      = r_state;
        n_out_valid  = 1'b0;
        n_out_trans  = r_out_trans;
        n_out_status = r_out_status;
        div_start    = 1'b0;
        div_dividend = {16'b0, i_wavelength - r_first};
        mem_raddr    = r_quot[tli_pkg::PT_AW-1:0];
        case (r_state)
            tli_pkg::S_IDLE: begin
                if (accept && (i_opcode == tli_pkg::OP_QUERY)) begin
                    if (n_eff == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_trans  = tli_pkg::ONE_Q15;
                        n_out_status = tli_pkg::ST_EMPTY;
                    end else if (i_wavelength < r_first) begin
                        n_out_valid  = 1'b1;
                        n_out_trans  = '0;
                        n_out_status = tli_pkg::ST_BELOW;
                    end else begin
                        div_start = 1'b1;
                        n_state   = tli_pkg::S_DIV1;
                    end
                end
            end
            tli_pkg::S_DIV1: begin
                if (div_res.done) begin
                    n_state = tli_pkg::S_CHECK;
                end
            end
            tli_pkg::S_CHECK: begin
                if (at_end) begin
                    mem_raddr = n_m1[tli_pkg::PT_AW-1:0];
                    n_state   = tli_pkg::S_END;
                end else begin
                    n_state = tli_pkg::S_RD_B;
                end
            end
            tli_pkg::S_END: begin
                n_out_valid  = 1'b1;
                n_out_trans  = mem_rdata;
                n_out_status = tli_pkg::ST_END;
                n_state      = tli_pkg::S_IDLE;
            end
            tli_pkg::S_RD_B: begin
                mem_raddr = r_quot[tli_pkg::PT_AW-1:0] + tli_pkg::PT_AW'(1);
                n_state   = tli_pkg::S_MUL_A;
            end
            tli_pkg::S_MUL_A: begin
                n_state = tli_pkg::S_MUL_B;
            end
            tli_pkg::S_MUL_B: begin
                n_state = tli_pkg::S_ADD;
            end
            tli_pkg::S_ADD: begin
                // rounded numerator stays below step * 2^16, so 16 steps suffice
                div_start    = 1'b1;
                div_dividend = r_acc + r_prod;
                n_state      = tli_pkg::S_DIV2;
            end
            tli_pkg::S_DIV2: begin
                if (div_res.done) begin
                    n_out_valid  = 1'b1;
                    n_out_trans  = div_res.quotient;
                    n_out_status = tli_pkg::ST_INTERP;
                    n_state      = tli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tli_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_trans  <= n_out_trans;
        r_out_status <= n_out_status;
        if (r_state == tli_pkg::S_DIV1 && div_res.done) begin
            r_quot <= div_res.quotient;
            r_rem  <= div_res.remainder;
        end
        if (r_state == tli_pkg::S_RD_B) begin
            r_a <= mem_rdata;
        end
        if (r_state == tli_pkg::S_MUL_A) begin
            r_b    <= mem_rdata;
            r_prod <= mul_p;
        end
        if (r_state == tli_pkg::S_MUL_B) begin
            // fold in half a step for round to nearest
            r_acc  <= r_prod + {17'b0, step_eff[15:1]};
            r_prod <= mul_p;
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_transmittance = r_out_trans;
    assign o_range_status  = r_out_status;

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_result_valid)
        else $error("result strobe while a query is in progress");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == tli_pkg::S_DIV1 || r_state == tli_pkg::S_DIV2))
        else $error("divider finished outside a wait state");

    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == tli_pkg::OP_QUERY && n_eff == '0)
            |=> (o_result_valid && o_range_status == tli_pkg::ST_EMPTY
                 && o_transmittance == tli_pkg::ONE_Q15))
        else $error("empty table query answered wrongly");

    a_busy_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_opcode == tli_pkg::OP_QUERY))
        else $error("busy rose without a query item");

endmodule

`default_nettype wire

>>> tb/sv/tb_table_linear_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_linear_interpolator: self-checking bench for the table interpolator
// Loads curve points, sends wavelength queries across several table settings
// and checks every answer against an in-bench interpolation model or a pinned value.
// ----------------------------------------------------------------------------

module tb_table_linear_interpolator;

    typedef struct packed {
        logic [15:0] trans;
        logic [1:0]  status;
    } t_answer;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        op;
        logic [5:0]  idx;
        logic [15:0] val;
        logic [15:0] wl;
        logic        pin;
        t_answer     ans;
        logic [15:0] c_first;
        logic [15:0] c_step;
        logic [6:0]  c_pts;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [5:0]  i_point_index;
    logic [15:0] i_point_value;
    logic [15:0] i_wavelength;
    logic        o_result_valid;
    logic [15:0] o_transmittance;
    logic [1:0]  o_range_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // hand-typed expectation travelling with the item
    logic        pin_valid;
    t_answer     pin_ans;

    // interpolation model state
    logic [15:0] curve_q15 [tli_pkg::MAX_POINTS];
    logic [15:0] cur_first_wl;
    logic [15:0] cur_step_wl;
    logic [6:0]  cur_points;

    t_answer     trans_expected_q [$];
    t_row        dir_rows [$];

    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned settings_used;
    int unsigned err_count;

    table_linear_interpolator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_point_index   (i_point_index),
        .i_point_value   (i_point_value),
        .i_wavelength    (i_wavelength),
        .o_result_valid  (o_result_valid),
        .o_transmittance (o_transmittance),
        .o_range_status  (o_range_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d answers outstanding", trans_expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_answer interp_transmittance(input logic [15:0] wl);
        t_answer     ans;
        int unsigned n;
        int unsigned stp;
        int unsigned d;
        int unsigned seg;
        int unsigned rem;
        logic [47:0] num;
        n   = (cur_points > tli_pkg::MAX_PTS_C) ? tli_pkg::MAX_POINTS : cur_points;
        stp = (cur_step_wl == 16'd0) ? 1 : cur_step_wl;
        if (n == 0) begin
            ans = '{tli_pkg::ONE_Q15, tli_pkg::ST_EMPTY};
        end else if (wl < cur_first_wl) begin
            ans = '{16'd0, tli_pkg::ST_BELOW};
        end else begin
            d   = wl - cur_first_wl;
            seg = d / stp;
            rem = d % stp;
            if (seg >= n - 1) begin
                ans = '{curve_q15[n-1], tli_pkg::ST_END};
            end else begin
                // weighted sum of the two neighbors, rounded half up
                num = 48'(curve_q15[seg]) * 48'(stp - rem)
                    + 48'(curve_q15[seg+1]) * 48'(rem) + 48'(stp / 2);
                ans = '{16'(num / 48'(stp)), tli_pkg::ST_INTERP};
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (i_rst_n) begin
            if (o_result_valid) begin
                got = '{o_transmittance, o_range_status};
                if (trans_expected_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected answer trans=%0d status=%0d",
                                 $realtime, got.trans, got.status);
                end else begin
                    want = trans_expected_q.pop_front();
                    results_checked++;
                    if (got.trans !== want.trans || got.status !== want.status) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"%0t: answer %0d: trans exp %0d got %0d,",
                                      " status exp %0d got %0d"},
                                     $realtime, results_checked, want.trans, got.trans,
                                     want.status, got.status);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tli_pkg::CFG_FIRST:  cur_first_wl = i_cfg_data;
                    tli_pkg::CFG_STEP:   cur_step_wl  = i_cfg_data;
                    tli_pkg::CFG_POINTS: cur_points   = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_opcode == tli_pkg::OP_LOAD) begin
                    curve_q15[i_point_index] = (i_point_value > tli_pkg::ONE_Q15)
                                             ? tli_pkg::ONE_Q15 : i_point_value;
                end else begin
                    trans_expected_q.push_back(pin_valid ? pin_ans
                                                         : interp_transmittance(i_wavelength));
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic [5:0] idx, input logic [15:0] val,
                             input logic [15:0] wl, input logic pin, input t_answer ans,
                             input bit gaps);
        start         <= 1'b1;
        i_opcode      <= op;
        i_point_index <= idx;
        i_point_value <= val;
        i_wavelength  <= wl;
        pin_valid     <= pin;
        pin_ans       <= ans;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // hold the sender until every answer is in and the block has settled
    task automatic drain_answers();
        start <= 1'b0;
        do @(posedge i_clk); while (trans_expected_q.size() != 0 || busy);
        repeat (48) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic [15:0] first_wl, input logic [15:0] step_wl,
                              input logic [6:0] pts);
        drain_answers();
        write_reg(tli_pkg::CFG_FIRST, first_wl);
        write_reg(tli_pkg::CFG_STEP, step_wl);
        write_reg(tli_pkg::CFG_POINTS, 16'(pts));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_item(input int unsigned first_wl, input int unsigned step_wl,
                                    input int unsigned pts, input bit gaps);
        int unsigned n_eff;
        int unsigned stp;
        int unsigned span;
        int unsigned wl;
        int unsigned pick;
        logic [15:0] val;
        n_eff = (pts > tli_pkg::MAX_POINTS) ? tli_pkg::MAX_POINTS : pts;
        stp   = (step_wl == 0) ? 1 : step_wl;
        span  = ((n_eff == 0) ? 1 : n_eff) * stp;
        pick  = $urandom_range(0, 19);
        if (pick < 3) begin
            val = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            send_item(tli_pkg::OP_LOAD, 6'($urandom), val, 16'($urandom), 1'b0, '0, gaps);
        end else begin
            case (pick)
                3:       wl = $urandom_range(0, 65535);
                4:       wl = (first_wl > 0) ? $urandom_range(0, first_wl - 1)
                                             : $urandom_range(0, 65535);
                5:       wl = first_wl + span + $urandom_range(0, 255);
                default: wl = first_wl + $urandom_range(0, span);
            endcase
            if (wl > 65535)
                wl = 65535;
            send_item(tli_pkg::OP_QUERY, 6'($urandom), 16'($urandom), 16'(wl), 1'b0, '0,
                      gaps);
        end
    endtask

    function automatic t_row row_load(input logic [5:0] idx, input logic [15:0] val);
        t_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.op   = tli_pkg::OP_LOAD;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic t_row row_query(input logic [15:0] wl);
        t_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.op   = tli_pkg::OP_QUERY;
        r.wl   = wl;
        return r;
    endfunction

    function automatic t_row row_query_exp(input logic [15:0] wl, input logic [15:0] trans,
                                           input logic [1:0] status);
        t_row r;
        r     = row_query(wl);
        r.pin = 1'b1;
        r.ans = '{trans, status};
        return r;
    endfunction

    function automatic t_row row_config(input logic [15:0] first_wl, input logic [15:0] step_wl,
                                        input logic [6:0] pts);
        t_row r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.c_first = first_wl;
        r.c_step  = step_wl;
        r.c_pts   = pts;
        return r;
    endfunction

    initial begin
        int unsigned ph_first;
        int unsigned ph_step;
        int unsigned ph_pts;
        t_row        r;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = tli_pkg::OP_LOAD;
        i_point_index = '0;
        i_point_value = '0;
        i_wavelength  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = tli_pkg::CFG_FIRST;
        i_cfg_data    = '0;
        pin_valid     = 1'b0;
        pin_ans       = '0;
        cur_first_wl  = 16'd0;
        cur_step_wl   = 16'd16;
        cur_points    = 7'd0;
        foreach (curve_q15[k])
            curve_q15[k] = 16'd0;
        items_sent      = 0;
        results_checked = 0;
        settings_used   = 0;
        err_count       = 0;

        dir_rows = '{
            // empty table after reset
            row_query_exp(16'd0, tli_pkg::ONE_Q15, tli_pkg::ST_EMPTY),
            row_query_exp(16'hFFFF, tli_pkg::ONE_Q15, tli_pkg::ST_EMPTY),
            row_load(6'd0, 16'd0),
            row_load(6'd1, tli_pkg::ONE_Q15),
            row_load(6'd2, 16'hFFFF),   // saturates to one
            row_load(6'd63, 16'h5A5A),
            // single point hit exactly and far past it
            row_config(16'd0, 16'd16, 7'd1),
            row_query_exp(16'd0, 16'd0, tli_pkg::ST_END),
            row_query_exp(16'hFFFF, 16'd0, tli_pkg::ST_END),
            row_config(16'd100, 16'd16, 7'd3),
            row_query_exp(16'd99, 16'd0, tli_pkg::ST_BELOW),
            row_query_exp(16'd100, 16'd0, tli_pkg::ST_INTERP),
            row_query(16'd108),
            row_query(16'd116),
            row_query(16'd124),
            row_query_exp(16'd132, tli_pkg::ONE_Q15, tli_pkg::ST_END),
            row_query_exp(16'd0, 16'd0, tli_pkg::ST_BELOW),
            // zero step behaves as one
            row_config(16'd0, 16'd0, 7'd3),
            row_query(16'd1),
            row_query_exp(16'd2, tli_pkg::ONE_Q15, tli_pkg::ST_END),
            // exact half rounds up
            row_config(16'd0, 16'd2, 7'd2),
            row_load(6'd1, 16'd1),
            row_query(16'd1),
            row_config(16'd0, 16'hFFFF, 7'd2),
            row_load(6'd1, tli_pkg::ONE_Q15),
            row_query(16'hFFFE),
            row_query_exp(16'hFFFF, tli_pkg::ONE_Q15, tli_pkg::ST_END)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.kind == ROW_CFG)
                set_config(r.c_first, r.c_step, r.c_pts);
            else
                send_item(r.op, r.idx, r.val, r.wl, r.pin, r.ans, 1'b1);
        end

        // fill the whole table so any point count reads written entries only
        for (int k = 0; k < tli_pkg::MAX_POINTS; k++)
            send_item(tli_pkg::OP_LOAD, 6'(k), 16'($urandom_range(0, 32768)),
                      16'($urandom), 1'b0, '0, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin ph_first = 0;     ph_step = 1;     ph_pts = 64;  end
                1: begin ph_first = 65535; ph_step = 65535; ph_pts = 64;  end
                2: begin
                    ph_first = $urandom_range(0, 65535);
                    ph_step  = $urandom_range(1, 64);
                    ph_pts   = 100;     // above the table size
                end
                3: begin
                    ph_first = $urandom_range(0, 4096);
                    ph_step  = 65535;
                    ph_pts   = 2;
                end
                4: begin
                    ph_first = $urandom_range(0, 16383);
                    ph_step  = $urandom_range(1, 300);
                    ph_pts   = $urandom_range(1, 64);
                end
                5: begin
                    ph_first = $urandom_range(0, 65535);
                    ph_step  = $urandom_range(1, 65535);
                    ph_pts   = 0;
                end
                6: begin
                    ph_first = $urandom_range(0, 8000);
                    ph_step  = $urandom_range(1, 1000);
                    ph_pts   = 127;
                end
                default: begin
                    ph_first = $urandom_range(0, 32767);
                    ph_step  = $urandom_range(1, 200);
                    ph_pts   = $urandom_range(1, 64);
                end
            endcase
            set_config(16'(ph_first), 16'(ph_step), 7'(ph_pts));
            for (int k = 0; k < 80; k++) begin
                if (ph == 3 && k == 40)
                    drain_answers();
                // last phase runs back to back
                send_random_item(ph_first, ph_step, ph_pts, ph != 7);
            end
        end

        start <= 1'b0;
        while (trans_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("ran %0d items over %0d table settings, %0d answers compared",
                 items_sent, settings_used, results_checked);
        $display("errors: %0d", err_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
